// File: rtl/brf_pkg.sv
package brf_pkg;

	localparam int DEF_STORE_DEPTH = 256;
	localparam int DEF_MAX_BURST   = 64;
	localparam int RING_LEN_CAP    = 256;
	localparam int CMDQ_DEPTH      = 2;
	localparam int RESQ_DEPTH      = 4;

	localparam logic [2:0] REQ_WRITE   = 3'd0;
	localparam logic [2:0] REQ_READ    = 3'd1;
	localparam logic [2:0] REQ_PEEK    = 3'd2;
	localparam logic [2:0] REQ_PEEK_AT = 3'd3;
	localparam logic [2:0] REQ_CLEAR   = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef enum logic [2:0] {
		KIND_WRITE   = 3'd0,
		KIND_READ    = 3'd1,
		KIND_PEEK    = 3'd2,
		KIND_PEEK_AT = 3'd3,
		KIND_CLEAR   = 3'd4
	} brf_kind_t;

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] write_data;
		logic [6:0] burst_len;
		logic [7:0] peek_offset;
	} brf_req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       data_valid;
		logic [1:0] status;
		logic       last;
		logic [7:0] used_count;
		logic [7:0] free_count;
	} brf_rsp_t;

	// classified request handed from front to back
	typedef struct packed {
		brf_kind_t  kind;
		logic [7:0] write_data;
		logic [6:0] burst_len;   // already capped at the max burst
		logic       zero_len;
		logic [7:0] peek_offset;
	} brf_cmd_t;

endpackage

// File: rtl/brf_front.sv
module brf_front #(
	parameter int MAX_BURST = brf_pkg::DEF_MAX_BURST
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  brf_pkg::brf_req_t req,
	output logic              cmd_valid,
	output brf_pkg::brf_cmd_t cmd,
	input  logic              cmd_pop
);

	localparam int QD  = brf_pkg::CMDQ_DEPTH;
	localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
	localparam int QCW = $clog2(QD + 1);

	brf_pkg::brf_cmd_t q_q [QD];
	logic [QAW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0]    cnt_q;

	brf_pkg::brf_cmd_t cls;
	logic              known;
	logic              do_push, do_pop;

	// classify: cap burst length, flag zero length, drop unused codes
	always_comb begin
		known           = (req.req_type <= brf_pkg::REQ_CLEAR);
		cls.kind        = brf_pkg::brf_kind_t'(req.req_type);
		cls.write_data  = req.write_data;
		cls.burst_len   = (32'(req.burst_len) > MAX_BURST) ? 7'(MAX_BURST) : req.burst_len;
		cls.zero_len    = (req.burst_len == 7'd0);
		cls.peek_offset = req.peek_offset;
	end

	assign full      = (cnt_q == QCW'(QD));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = q_q[rd_ptr_q];
	assign do_push   = push && !full && known;
	assign do_pop    = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) q_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (32'(wr_ptr_q) == QD - 1) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= (32'(rd_ptr_q) == QD - 1) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// File: rtl/brf_resq.sv
module brf_resq #(
	parameter int DEPTH = brf_pkg::RESQ_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  brf_pkg::brf_rsp_t          wr_data,
	output logic                       empty,
	input  logic                       pop,
	output brf_pkg::brf_rsp_t          rsp,
	output logic [$clog2(DEPTH+1)-1:0] level
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	brf_pkg::brf_rsp_t q_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]     cnt_q;
	logic              do_pop;

	assign empty  = (cnt_q == '0);
	assign rsp    = q_q[rd_ptr_q];
	assign level  = cnt_q;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr_en) q_q[wr_ptr_q] <= wr_data;
	end

	// writer never overruns: the back end reserves a slot before issuing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en)  wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			if (wr_en && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !wr_en) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// File: rtl/brf_back.sv
module brf_back #(
	parameter int STORE_DEPTH = brf_pkg::DEF_STORE_DEPTH
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [8:0]                             cfg_wr_data,
	input  logic                                   cmd_valid,
	input  brf_pkg::brf_cmd_t                      cmd,
	output logic                                   cmd_pop,
	input  logic [$clog2(brf_pkg::RESQ_DEPTH+1)-1:0] resq_level,
	output logic                                   res_wr,
	output brf_pkg::brf_rsp_t                      res
);

	localparam int LEN_MAX = (STORE_DEPTH < brf_pkg::RING_LEN_CAP) ?
		STORE_DEPTH : brf_pkg::RING_LEN_CAP;
	localparam int AW = $clog2(LEN_MAX);

	// ring state
	logic [8:0] len_q;
	logic [7:0] head_q, tail_q, fill_q;
	// burst in progress
	logic       busy_q, rmv_q;
	logic [7:0] pos_q;
	logic [6:0] rem_q;
	// result stage
	logic       valid_s2, use_mem_s2, last_s2;
	logic [1:0] status_s2;
	logic [7:0] used_s2, free_s2, rdata_s2;

	logic [7:0] mem [LEN_MAX];

	logic       room, issue, use_mem, last, do_step, step_rmv;
	logic [1:0] status;
	logic [7:0] raddr, step_pos, step_nxt, n_start;
	logic [6:0] step_rem;
	logic       mem_we;
	logic [8:0] sum, cfg_len;
	logic [7:0] head_n, tail_n, fill_n, pos_n;
	logic [6:0] rem_n;
	logic       busy_n, rmv_n;

	function automatic logic [7:0] wrap_inc(input logic [7:0] p, input logic [8:0] l);
		logic [8:0] s;
		s = {1'b0, p} + 9'd1;
		return (s >= l) ? 8'd0 : s[7:0];
	endfunction

	// reserve a result-queue slot for the item about to enter the result stage
	assign room = (32'(resq_level) + 32'(valid_s2)) < brf_pkg::RESQ_DEPTH;

	always_comb begin
		if (cfg_wr_data < 9'd2)                cfg_len = 9'd2;
		else if (32'(cfg_wr_data) > LEN_MAX)   cfg_len = 9'(LEN_MAX);
		else                                   cfg_len = cfg_wr_data;
	end

	always_comb begin
		cmd_pop  = 1'b0;
		issue    = 1'b0;
		use_mem  = 1'b0;
		last     = 1'b1;
		status   = brf_pkg::ST_OK;
		mem_we   = 1'b0;
		raddr    = head_q;
		do_step  = 1'b0;
		step_pos = pos_q;
		step_rem = rem_q;
		step_rmv = rmv_q;
		step_nxt = 8'd0;
		n_start  = 8'd0;
		sum      = 9'd0;
		head_n   = head_q;
		tail_n   = tail_q;
		fill_n   = fill_q;
		pos_n    = pos_q;
		rem_n    = rem_q;
		busy_n   = busy_q;
		rmv_n    = rmv_q;

		if (busy_q) begin
			do_step = room;
		end else if (cmd_valid && room) begin
			cmd_pop = 1'b1;
			case (cmd.kind)
				brf_pkg::KIND_WRITE: begin
					issue = 1'b1;
					if ({1'b0, fill_q} < len_q - 9'd1) begin
						mem_we = 1'b1;
						tail_n = wrap_inc(tail_q, len_q);
						fill_n = fill_q + 8'd1;
					end else begin
						status = brf_pkg::ST_FULL;
					end
				end
				brf_pkg::KIND_READ, brf_pkg::KIND_PEEK: begin
					if (cmd.zero_len || fill_q == 8'd0) begin
						issue  = 1'b1;
						status = brf_pkg::ST_EMPTY;
					end else begin
						n_start  = ({1'b0, cmd.burst_len} > fill_q) ? fill_q
							: {1'b0, cmd.burst_len};
						do_step  = 1'b1;
						step_pos = head_q;
						step_rem = n_start[6:0];
						step_rmv = (cmd.kind == brf_pkg::KIND_READ);
					end
				end
				brf_pkg::KIND_PEEK_AT: begin
					issue = 1'b1;
					if (cmd.peek_offset >= fill_q) begin
						status = brf_pkg::ST_RANGE;
					end else begin
						sum = {1'b0, head_q} + {1'b0, cmd.peek_offset};
						if (sum >= len_q) sum = sum - len_q;
						raddr   = sum[7:0];
						use_mem = 1'b1;
					end
				end
				brf_pkg::KIND_CLEAR: begin
					issue  = 1'b1;
					head_n = 8'd0;
					tail_n = 8'd0;
					fill_n = 8'd0;
				end
				default: begin
					issue = 1'b0;
				end
			endcase
		end

		// one byte of a burst
		if (do_step) begin
			step_nxt = wrap_inc(step_pos, len_q);
			raddr    = step_pos;
			use_mem  = 1'b1;
			issue    = 1'b1;
			last     = (step_rem == 7'd1);
			if (step_rmv) begin
				head_n = step_nxt;
				fill_n = fill_q - 8'd1;
			end
			pos_n  = step_nxt;
			rem_n  = step_rem - 7'd1;
			busy_n = (step_rem != 7'd1);
			rmv_n  = step_rmv;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[tail_q[AW-1:0]] <= cmd.write_data;
		rdata_s2 <= mem[raddr[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= 9'(LEN_MAX);
			head_q   <= '0;
			tail_q   <= '0;
			fill_q   <= '0;
			busy_q   <= 1'b0;
			rmv_q    <= 1'b0;
			pos_q    <= '0;
			rem_q    <= '0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= issue;
			if (cfg_wr_en) begin
				len_q  <= cfg_len;
				head_q <= '0;
				tail_q <= '0;
				fill_q <= '0;
			end else begin
				head_q <= head_n;
				tail_q <= tail_n;
				fill_q <= fill_n;
			end
			busy_q <= busy_n;
			rmv_q  <= rmv_n;
			pos_q  <= pos_n;
			rem_q  <= rem_n;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			use_mem_s2 <= use_mem;
			status_s2  <= status;
			last_s2    <= last;
			used_s2    <= fill_n;
			free_s2    <= 8'(len_q - {1'b0, fill_n} - 9'd1);
		end
	end

	assign res_wr         = valid_s2;
	assign res.read_data  = use_mem_s2 ? rdata_s2 : 8'd0;
	assign res.data_valid = use_mem_s2;
	assign res.status     = status_s2;
	assign res.last       = last_s2;
	assign res.used_count = used_s2;
	assign res.free_count = free_s2;

endmodule

// File: rtl/byte_ring_fifo_with_peek.sv
// Byte ring FIFO with burst read, burst peek and peek at an offset. Requests
// go in through a queue-style port (push/full) and results come out through
// another (empty/pop); each request of a known type yields one result, except
// a read or peek burst that returns bytes, which yields one result per byte
// returned, with last marking the final one; requests with unused type codes
// are dropped. Every result carries the used and free counts after it.
// Throughput is one result per cycle while the result queue has room: the
// back end handles one write, clear, peek at offset, failed burst or burst
// byte at a time, and takes no new command until a burst is done. When
// nothing stalls, the transfer loads the command queue, the back end takes
// the command and loads the result stage and memory read register, and the
// result stage then writes the result queue.
// The ring length register holds 2 to 256 slots (saturated, and capped at
// STORE_DEPTH); writing it empties the ring and must only be done while the
// block is idle. No clearing pass is needed after reset.
module byte_ring_fifo_with_peek #(
	parameter int STORE_DEPTH = brf_pkg::DEF_STORE_DEPTH,
	parameter int MAX_BURST   = brf_pkg::DEF_MAX_BURST
) (
	input  logic              clk,
	input  logic              arst_n,
	// request side
	input  logic              push,
	output logic              full,
	input  brf_pkg::brf_req_t req,
	// result side
	output logic              empty,
	input  logic              pop,
	output brf_pkg::brf_rsp_t rsp,
	// ring length register
	input  logic              cfg_wr_en,
	input  logic [8:0]        cfg_wr_data
);

	logic                                     cmd_valid, cmd_pop;
	brf_pkg::brf_cmd_t                        cmd;
	logic                                     res_wr;
	brf_pkg::brf_rsp_t                        res;
	logic [$clog2(brf_pkg::RESQ_DEPTH+1)-1:0] resq_level;

	// front: takes each transfer, classifies it, buffers it
	brf_front #(
		.MAX_BURST (MAX_BURST)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// back: ring state, byte store, burst sequencing
	brf_back #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop),
		.resq_level  (resq_level),
		.res_wr      (res_wr),
		.res         (res)
	);

	// results wait here until popped; back end stalls on its own when it fills
	brf_resq #(
		.DEPTH (brf_pkg::RESQ_DEPTH)
	) u_resq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_wr),
		.wr_data (res),
		.empty   (empty),
		.pop     (pop),
		.rsp     (rsp),
		.level   (resq_level)
	);

endmodule
